[hdl/dll_pkg.sv]
// ============================================================================
// dll_pkg: shared types and constants for the linked list engine
// Opcodes, status codes, widths and the sequencer state encoding.
// ============================================================================
package dll_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_BITS  = 32;
    localparam int SLOT_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [KEY_BITS-1:0]  key_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_DEL_KEY = 3'd1;
    localparam logic [2:0] OP_DEL_FST = 3'd2;
    localparam logic [2:0] OP_DEL_LST = 3'd3;
    localparam logic [2:0] OP_DUMP    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXAM,
        S_LINK,
        S_EMIT
    } state_t;

    // node memory access from the sequencer
    typedef struct packed {
        logic  rd_en;
        slot_t rd_addr;
        logic  key_we;
        slot_t key_addr;
        key_t  key_wdata;
        logic  nxt_we;
        slot_t nxt_addr;
        slot_t nxt_wdata;
        logic  prv_we;
        slot_t prv_addr;
        slot_t prv_wdata;
    } mem_req_t;

    typedef struct packed {
        key_t  key;
        slot_t nxt;
        slot_t prv;
    } mem_rsp_t;

    // input transaction: opcode in the upper bits, key below it
    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] key_in;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] key_out;
        logic        key_valid;
        logic        last;
    } result_t;

endpackage

[hdl/dll_if.sv]
// ============================================================================
// dll_if: valid/ready channel carrying one payload
// Source drives valid and payload, sink drives ready.
// ============================================================================
interface dll_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/dll_node_mem.sv]
// ============================================================================
// dll_node_mem: node pool storage
// Key, next and prev arrays, one read port with registered data.
// ============================================================================
module dll_node_mem (
    input  logic              clk,
    input  dll_pkg::mem_req_t req,
    output dll_pkg::mem_rsp_t rsp
);

    dll_pkg::key_t  key_mem [dll_pkg::CAPACITY];
    dll_pkg::slot_t nxt_mem [dll_pkg::CAPACITY];
    dll_pkg::slot_t prv_mem [dll_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.key_we)
        begin
            key_mem[req.key_addr] <= req.key_wdata;
        end
        if (req.nxt_we)
        begin
            nxt_mem[req.nxt_addr] <= req.nxt_wdata;
        end
        if (req.prv_we)
        begin
            prv_mem[req.prv_addr] <= req.prv_wdata;
        end
        if (req.rd_en)
        begin
            rsp.key <= key_mem[req.rd_addr];
            rsp.nxt <= nxt_mem[req.rd_addr];
            rsp.prv <= prv_mem[req.rd_addr];
        end
    end

endmodule

[hdl/dll_seq.sv]
// ============================================================================
// dll_seq: list operation sequencer
// Walks and relinks the list through the node memory, one transaction at a time.
// ============================================================================
module dll_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         in_opcode,
    input  logic [31:0]        in_key,
    output logic               res_valid,
    input  logic               res_ready,
    output dll_pkg::result_t   res,
    output dll_pkg::mem_req_t  mreq,
    input  dll_pkg::mem_rsp_t  mrsp
);

    dll_pkg::state_t                   state_reg, state_next;
    logic [2:0]                        op_reg, op_next;
    dll_pkg::key_t                     key_reg, key_next;
    dll_pkg::slot_t                    front_reg, front_next;
    dll_pkg::slot_t                    back_reg, back_next;
    logic [dll_pkg::CAPACITY-1:0]      free_reg, free_next;
    dll_pkg::cnt_t                     count_reg, count_next;
    dll_pkg::slot_t                    cur_reg, cur_next;
    dll_pkg::cnt_t                     idx_reg, idx_next;
    logic                              rv_reg, rv_next;
    dll_pkg::result_t                  res_reg, res_next;

    dll_pkg::slot_t low_free;
    logic           any_free;

    // lowest free slot
    always_comb
    begin
        low_free = '0;
        any_free = 1'b0;
        for (int i = dll_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                low_free = dll_pkg::slot_t'(i);
                any_free = 1'b1;
            end
        end
    end

    function automatic logic [31:0] key_to_out(dll_pkg::key_t k);
        logic [63:0] w;
        w = 64'(signed'(k));
        return w[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dll_pkg::S_IDLE;
            front_reg <= '0;
            back_reg  <= '0;
            free_reg  <= '1;
            count_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            back_reg  <= back_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

    assign res_valid = rv_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        front_next = front_reg;
        back_next  = back_reg;
        free_next  = free_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        rv_next    = rv_reg;
        in_ready   = 1'b0;
        mreq       = '0;
        if (rv_reg && res_ready)
        begin
            rv_next = 1'b0;
        end
        unique case (state_reg)
            dll_pkg::S_IDLE:
            begin
                in_ready = !rv_reg || res_ready;
                if (in_valid && in_ready)
                begin
                    op_next  = in_opcode;
                    key_next = dll_pkg::key_t'(signed'(in_key));
                    cur_next = front_reg;
                    idx_next = '0;
                    res_next = '{status: dll_pkg::ST_OK, key_out: '0,
                                 key_valid: 1'b0, last: 1'b1};
                    case (in_opcode) inside
                        dll_pkg::OP_INSERT:
                        begin
                            if (!any_free)
                            begin
                                res_next.status = dll_pkg::ST_FULL;
                                rv_next = 1'b1;
                            end
                            else
                            begin
                                mreq.key_we    = 1'b1;
                                mreq.key_addr  = low_free;
                                mreq.key_wdata = dll_pkg::key_t'(signed'(in_key));
                                mreq.nxt_we    = 1'b1;
                                mreq.nxt_addr  = low_free;
                                mreq.nxt_wdata = front_reg;
                                mreq.prv_we    = 1'b1;
                                mreq.prv_addr  = (count_reg == '0) ? low_free : front_reg;
                                mreq.prv_wdata = low_free;
                                if (count_reg == '0)
                                begin
                                    back_next = low_free;
                                end
                                front_next = low_free;
                                free_next[low_free] = 1'b0;
                                count_next = count_reg + 1'b1;
                                rv_next = 1'b1;
                            end
                        end
                        dll_pkg::OP_DEL_KEY, dll_pkg::OP_DEL_FST,
                        dll_pkg::OP_DEL_LST, dll_pkg::OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = dll_pkg::ST_EMPTY;
                                rv_next = 1'b1;
                            end
                            else
                            begin
                                if (in_opcode == dll_pkg::OP_DEL_LST)
                                begin
                                    cur_next = back_reg;
                                end
                                state_next = dll_pkg::S_READ;
                            end
                        end
                        default:
                        begin
                            rv_next = 1'b1;
                        end
                    endcase
                end
            end
            dll_pkg::S_READ:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = cur_reg;
                state_next   = (op_reg == dll_pkg::OP_DUMP) ? dll_pkg::S_EMIT
                                                            : dll_pkg::S_EXAM;
            end
            dll_pkg::S_EXAM:
            begin
                // node data in mrsp; decide match, advance or report not found
                if (op_reg != dll_pkg::OP_DEL_KEY || mrsp.key == key_reg)
                begin
                    state_next = dll_pkg::S_LINK;
                end
                else if (idx_reg + 1'b1 == count_reg)
                begin
                    if (!rv_reg || res_ready)
                    begin
                        res_next.status = dll_pkg::ST_NOTFOUND;
                        rv_next    = 1'b1;
                        state_next = dll_pkg::S_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    cur_next = mrsp.nxt;
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = mrsp.nxt;
                end
            end
            dll_pkg::S_LINK:
            begin
                // unlink cur_reg; node data still held in mrsp
                if (!rv_reg || res_ready)
                begin
                    if (cur_reg == front_reg)
                    begin
                        front_next = mrsp.nxt;
                    end
                    else
                    begin
                        mreq.nxt_we    = 1'b1;
                        mreq.nxt_addr  = mrsp.prv;
                        mreq.nxt_wdata = mrsp.nxt;
                    end
                    if (cur_reg == back_reg)
                    begin
                        back_next = mrsp.prv;
                    end
                    else
                    begin
                        mreq.prv_we    = 1'b1;
                        mreq.prv_addr  = mrsp.nxt;
                        mreq.prv_wdata = mrsp.prv;
                    end
                    free_next[cur_reg] = 1'b1;
                    count_next = count_reg - 1'b1;
                    rv_next    = 1'b1;
                    state_next = dll_pkg::S_IDLE;
                end
            end
            dll_pkg::S_EMIT:
            begin
                // hold node data until the result register frees
                if (!rv_reg || res_ready)
                begin
                    res_next.key_out   = key_to_out(mrsp.key);
                    res_next.key_valid = 1'b1;
                    res_next.last      = (idx_reg + 1'b1 == count_reg);
                    rv_next            = 1'b1;
                    if (idx_reg + 1'b1 == count_reg)
                    begin
                        state_next = dll_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next     = idx_reg + 1'b1;
                        cur_next     = mrsp.nxt;
                        mreq.rd_en   = 1'b1;
                        mreq.rd_addr = mrsp.nxt;
                    end
                end
            end
            default:
            begin
                state_next = dll_pkg::S_IDLE;
            end
        endcase
    end

    a_count_free: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(free_reg) + count_reg == dll_pkg::CAPACITY)
        else $error("free map and entry count disagree");
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != dll_pkg::S_IDLE |-> !in_ready)
        else $error("input taken while busy");
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && !res_ready |=> rv_reg && $stable(res_reg))
        else $error("stalled result changed");

endmodule

[hdl/doubly_linked_list_engine_top.sv]
// ============================================================================
// doubly_linked_list_engine_top: bounded doubly linked list of keys
// Insert front, delete by key, delete first/last and dump over a node pool.
// ============================================================================
// One transaction is handled at a time. Insert and any failed check finish at
// acceptance. Delete first/last step through accept, read node, examine and
// relink. Delete by key reads the front node, examines each node in turn and
// relinks the first match; a key that is not found ends after the last node.
// Dump emits the nodes front to back. The walk rate is set by the single read
// port of the node memory: one linked node per cycle while the output is not
// stalled. Results sit in an output register, so a stalled consumer holds the
// walk without losing data. No clearing pass is needed after reset.
module doubly_linked_list_engine_top (
    input  logic clk,
    input  logic rst_n,
    dll_if.sink  in_ch,
    dll_if.source out_ch
);

    dll_pkg::mem_req_t mreq;
    dll_pkg::mem_rsp_t mrsp;
    dll_pkg::result_t  res;

    // node pool storage
    dll_node_mem u_mem (
        .clk (clk),
        .req (mreq),
        .rsp (mrsp)
    );

    // operation sequencer; input payload is {opcode, key_in}
    dll_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_opcode (in_ch.payload.opcode),
        .in_key    (in_ch.payload.key_in),
        .res_valid (out_ch.valid),
        .res_ready (out_ch.ready),
        .res       (res),
        .mreq      (mreq),
        .mrsp      (mrsp)
    );

    assign out_ch.payload.status    = res.status;
    assign out_ch.payload.key_out   = res.key_out;
    assign out_ch.payload.key_valid = res.key_valid;
    assign out_ch.payload.last      = res.last;

endmodule

[tb/doubly_linked_list_engine_top_tb.sv]
// ============================================================================
// doubly_linked_list_engine_top_tb: self-checking bench for the list engine
// Drives opcode/key transactions into the engine and keeps its own copy of the
// list as a queue of keys, front first. Every response is compared field by
// field with the oldest pending prediction. Both channels idle at random.
// ============================================================================
module doubly_linked_list_engine_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;  // cycles with no transaction at all
    localparam int RANDOM_OPS = 330;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dll_if #(.payload_t(dll_pkg::request_t)) in_ch ();
    dll_if #(.payload_t(dll_pkg::result_t))  out_ch ();

    doubly_linked_list_engine_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #4 clk = ~clk;

    // Predictor state: the list contents, front at index 0.
    logic [31:0]      list_keys[$];
    // Responses that the engine still owes us, oldest first.
    dll_pkg::result_t pending_results[$];
    int               error_count = 0;
    int               stall_free  = 0;   // while set, neither side idles
    int               quiet_cycles = 0;

    // ------------------------------------------------------------------------
    // Predict the responses of one accepted request and update the list copy.
    // ------------------------------------------------------------------------
    task automatic predict_request(input logic [2:0] op, input logic [31:0] key);
        dll_pkg::result_t r;
        int               hit;
        hit = -1;
        r = '{status: dll_pkg::ST_OK, key_out: 32'd0, key_valid: 1'b0, last: 1'b1};
        case (op)
            dll_pkg::OP_INSERT:
            begin
                if (list_keys.size() >= dll_pkg::CAPACITY)
                    r.status = dll_pkg::ST_FULL;
                else
                    list_keys.push_front(key);
            end
            dll_pkg::OP_DEL_KEY:
            begin
                if (list_keys.size() == 0)
                    r.status = dll_pkg::ST_EMPTY;
                else
                begin
                    // first match from the front wins
                    foreach (list_keys[i])
                        if (hit < 0 && list_keys[i] == key)
                            hit = i;
                    if (hit < 0)
                        r.status = dll_pkg::ST_NOTFOUND;
                    else
                        list_keys.delete(hit);
                end
            end
            dll_pkg::OP_DEL_FST:
            begin
                if (list_keys.size() == 0)
                    r.status = dll_pkg::ST_EMPTY;
                else
                    void'(list_keys.pop_front());
            end
            dll_pkg::OP_DEL_LST:
            begin
                if (list_keys.size() == 0)
                    r.status = dll_pkg::ST_EMPTY;
                else
                    void'(list_keys.pop_back());
            end
            dll_pkg::OP_DUMP:
            begin
                if (list_keys.size() == 0)
                    r.status = dll_pkg::ST_EMPTY;
                else
                begin
                    foreach (list_keys[i])
                    begin
                        r.key_out   = list_keys[i];
                        r.key_valid = 1'b1;
                        r.last      = (i == list_keys.size() - 1);
                        pending_results.push_back(r);
                    end
                    return;
                end
            end
            default: ;  // unused opcodes answer ok and change nothing
        endcase
        pending_results.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Send one request. Valid stays high across back-to-back requests; drop it
    // only when a random idle gap is inserted.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [2:0] op, input logic [31:0] key);
        int gap;
        if (!stall_free && $urandom_range(99) < 10)
        begin
            gap = $urandom_range(4, 1);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= '{opcode: op, key_in: key};
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_request(op, key);
    endtask

    // Hold the sender until every predicted response has arrived.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Pick a key: often one already in the list, so deletes by key hit.
    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45 && list_keys.size() != 0)
            return list_keys[$urandom_range(list_keys.size() - 1)];
        else if (sel < 60)
            return $urandom_range(15);
        else
            return $urandom();
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_empty_list();
        send_request(dll_pkg::OP_DUMP, 32'd0);
        send_request(dll_pkg::OP_DEL_KEY, 32'd5);
        send_request(dll_pkg::OP_DEL_FST, 32'hFFFF_FFFF);
        send_request(dll_pkg::OP_DEL_LST, 32'd0);
    endtask

    task automatic test_basic_ops();
        send_request(dll_pkg::OP_INSERT, 32'h8000_0000);
        send_request(dll_pkg::OP_INSERT, 32'h7FFF_FFFF);
        send_request(dll_pkg::OP_INSERT, 32'd0);
        send_request(dll_pkg::OP_INSERT, 32'hFFFF_FFFF);
        send_request(dll_pkg::OP_INSERT, 32'd0);         // duplicate: first match goes
        send_request(dll_pkg::OP_DUMP, 32'd0);
        send_request(dll_pkg::OP_DEL_KEY, 32'd12345);    // no match
        send_request(dll_pkg::OP_DEL_KEY, 32'd0);
        send_request(dll_pkg::OP_DEL_KEY, 32'h8000_0000); // back node by key
        send_request(dll_pkg::OP_DUMP, 32'd0);
        send_request(3'd5, 32'd1);
        send_request(3'd6, 32'd2);
        send_request(3'd7, 32'd3);
        send_request(dll_pkg::OP_DEL_FST, 32'd0);
        send_request(dll_pkg::OP_DEL_LST, 32'd0);
        send_request(dll_pkg::OP_DEL_LST, 32'd0);        // single node left
        send_request(dll_pkg::OP_DUMP, 32'd0);
    endtask

    task automatic test_full_pool();
        for (int i = 0; i < dll_pkg::CAPACITY; i++)
            send_request(dll_pkg::OP_INSERT, $urandom());
        send_request(dll_pkg::OP_INSERT, 32'hDEAD_BEEF); // full
        send_request(dll_pkg::OP_DUMP, 32'd0);
        // delete the back node by key: longest walk
        send_request(dll_pkg::OP_DEL_KEY, list_keys[list_keys.size() - 1]);
        wait_drained();
        while (list_keys.size() != 0)
            send_request($urandom_range(1) ? dll_pkg::OP_DEL_FST : dll_pkg::OP_DEL_LST,
                         32'd0);
        send_request(dll_pkg::OP_DUMP, 32'd0);
    endtask

    task automatic test_random_ops();
        int          sel;
        logic [2:0]  op;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            // a stretch with no idling on either side
            stall_free = (n >= 200 && n < 280);
            sel = $urandom_range(99);
            // bias inserts up while the list is short, down when it is long
            if (sel < (list_keys.size() < 20 ? 45 : 25))
                op = dll_pkg::OP_INSERT;
            else if (sel < 60)
                op = dll_pkg::OP_DEL_KEY;
            else if (sel < 72)
                op = dll_pkg::OP_DEL_FST;
            else if (sel < 84)
                op = dll_pkg::OP_DEL_LST;
            else if (sel < 95)
                op = dll_pkg::OP_DUMP;
            else
                op = 3'($urandom_range(7, 5));
            send_request(op, pick_key());
            if (n == 300)
                wait_drained();
        end
        stall_free = 0;
    endtask

    // ------------------------------------------------------------------------
    // Response side: random back-pressure and the scoreboard.
    // ------------------------------------------------------------------------
    always @(posedge clk)
        out_ch.ready <= stall_free || ($urandom_range(99) >= 10);

    always @(posedge clk)
    begin
        dll_pkg::result_t want;
        dll_pkg::result_t got;
        if (out_ch.valid && out_ch.ready)
        begin
            got = out_ch.payload;
            if (pending_results.size() == 0)
            begin
                $error("unexpected response: status %0d key_out %h", got.status,
                       got.key_out);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
                if (got.key_out !== want.key_out)
                begin
                    $error("key_out: expected %h, got %h", want.key_out, got.key_out);
                    error_count++;
                end
                if (got.key_valid !== want.key_valid)
                begin
                    $error("key_valid: expected %b, got %b", want.key_valid,
                           got.key_valid);
                    error_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: advance a counter on every cycle with no transaction.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("** doubly_linked_list_engine_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_basic_ops();
        test_full_pool();
        test_random_ops();

        wait_drained();
        // let any trailing activity show up as an unexpected response
        repeat (200) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("** doubly_linked_list_engine_top: PASSED **");
        else
            $display("** doubly_linked_list_engine_top: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
hdl/dll_pkg.sv
hdl/dll_if.sv
hdl/dll_node_mem.sv
hdl/dll_seq.sv
hdl/doubly_linked_list_engine_top.sv
tb/doubly_linked_list_engine_top_tb.sv
